/* sv/psu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

    // Table sizing: pids are four bits wide, so at most sixteen slots are used.
    localparam int PROCESS_COUNT = 16;
    localparam int PID_SLOTS     = (PROCESS_COUNT < 16) ? PROCESS_COUNT : 16;
    localparam int PID_W         = 4;
    localparam int CNT_W         = 5;
    localparam int TBL_DEPTH     = 16;
    localparam int MAX_RESULTS   = 16;

    localparam logic [PID_W-1:0] SEM_ID      = 4'd1;
    localparam logic [15:0]      SLICE_RESET = 16'd300;

    // Operation codes.
    localparam logic [2:0] FUNC_NEW   = 3'd0;
    localparam logic [2:0] FUNC_TICK  = 3'd1;
    localparam logic [2:0] FUNC_SLEEP = 3'd2;
    localparam logic [2:0] FUNC_WAIT  = 3'd3;
    localparam logic [2:0] FUNC_POST  = 3'd4;

    // Process states.
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_SLEEP = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_PID  = 2'd1;
    localparam logic [1:0] ERR_BAD_SEM = 2'd2;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] wake;
        logic [15:0] run;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             rel;
        logic [PID_W-1:0] new_pid;
        logic [1:0]       err;
    } flags_t;

    // Commands from the sequencer to the result queue.
    typedef struct packed {
        logic             start;
        logic             push;
        logic [PID_W-1:0] push_pid;
        logic             finish;
        flags_t           flags;
    } q_ctrl_t;

endpackage

`default_nettype wire

/* sv/process_tick_sleep_semaphore_unit.sv */
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   func, running_pid, running_valid,
//                                            sleep_ticks, sem_number
// out       output     out_valid / out_ready ready_pid, ready_valid, release_running,
//                                            new_pid, error_code, last
// cfg       input      APB write/read        slice_limit at byte address 0
//
// A new process, an unknown operation and any operation that ends in an error
// or only touches a counter finish in the cycle of acceptance. Sleep and
// semaphore wait finish in S_PRE, a semaphore post in S_POST after S_FIFO: the
// process table and the waiter memory have registered reads. A tick passes S_PRE,
// S_WALK and S_TAIL, walking the table one entry a cycle. Results then stream
// out one a cycle while out_ready is high; the next transaction is taken once
// the last result has been accepted. The table needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module process_tick_sleep_semaphore_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [3:0]  running_pid,
    input  wire logic        running_valid,
    input  wire logic [31:0] sleep_ticks,
    input  wire logic [3:0]  sem_number,
    // result transactions
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [3:0]  ready_pid,
    output logic             ready_valid,
    output logic             release_running,
    output logic      [3:0]  new_pid,
    output logic      [1:0]  error_code,
    output logic             last,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int PW = psu_pkg::PID_W;
    localparam int CW = psu_pkg::CNT_W;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PRE  = 6'b000010,
        S_WALK = 6'b000100,
        S_TAIL = 6'b001000,
        S_FIFO = 6'b010000,
        S_POST = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [PW-1:0]      rpid_reg, rpid_next;
    logic               running_reg, running_next;
    logic               charged_reg, charged_next;
    logic [31:0]        ticks_reg, ticks_next;
    logic [15:0]        slice_reg;
    logic [31:0]        clock_reg, clock_next;
    logic [PW-1:0]      free_head_reg, free_head_next;
    logic [CW-1:0]      free_count_reg, free_count_next;
    logic [15:0]        sem_value_reg, sem_value_next;
    logic [PW-1:0]      whead_reg, whead_next;
    logic [CW-1:0]      wcount_reg, wcount_next;
    logic [PW-1:0]      walk_reg, walk_next;
    logic               rel_reg, rel_next;
    logic [15:0]        run_new_reg, run_new_next;
    logic               woken_reg, woken_next;
    logic [PW-1:0]      post_pid_reg, post_pid_next;
    logic [psu_pkg::TBL_DEPTH-1:0] valid_reg, valid_next;
    logic               rd_valid_reg;

    // Process table and waiter memory ports.
    logic               tbl_we;
    logic [PW-1:0]      tbl_waddr, tbl_raddr;
    psu_pkg::entry_t    tbl_wdata, tbl_rdata, entry_rd;
    logic               fifo_we;
    logic [PW-1:0]      fifo_waddr, fifo_raddr, fifo_rdata;

    psu_pkg::q_ctrl_t   q_ctrl;
    logic               q_busy;

    logic               accept;
    logic               running_in;
    logic [15:0]        run_inc;
    logic               wake_hit;
    psu_pkg::entry_t    walk_entry;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {16'd0, slice_reg};

    assign in_ready   = (state_reg == S_IDLE) && !q_busy;
    assign accept     = in_valid && in_ready;
    assign running_in = running_valid &&
                        ({1'b0, running_pid} < CW'(psu_pkg::PID_SLOTS));

    // An entry never written since reset reads as free with zero fields.
    assign entry_rd = rd_valid_reg ? tbl_rdata : '0;
    assign run_inc  = (entry_rd.run == 16'hFFFF) ? entry_rd.run : entry_rd.run + 16'd1;
    assign wake_hit = (entry_rd.st == psu_pkg::ST_SLEEP) && (entry_rd.wake == clock_reg);

    always_comb
    begin
        walk_entry = entry_rd;
        if (wake_hit)
        begin
            walk_entry.st = psu_pkg::ST_READY;
        end
        if (charged_reg && (walk_reg == rpid_reg))
        begin
            walk_entry.run = run_new_reg;
            if (rel_reg)
            begin
                walk_entry.st = psu_pkg::ST_READY;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        rpid_next       = rpid_reg;
        running_next    = running_reg;
        charged_next    = charged_reg;
        ticks_next      = ticks_reg;
        clock_next      = clock_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        sem_value_next  = sem_value_reg;
        whead_next      = whead_reg;
        wcount_next     = wcount_reg;
        walk_next       = walk_reg;
        rel_next        = rel_reg;
        run_new_next    = run_new_reg;
        woken_next      = woken_reg;
        post_pid_next   = post_pid_reg;
        valid_next      = valid_reg;

        tbl_we     = 1'b0;
        tbl_waddr  = '0;
        tbl_wdata  = '0;
        tbl_raddr  = rpid_reg;
        fifo_we    = 1'b0;
        fifo_waddr = whead_reg + wcount_reg[PW-1:0];
        fifo_raddr = whead_reg;
        q_ctrl     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = func;
                    rpid_next     = running_pid;
                    running_next  = running_in;
                    charged_next  = running_in && (running_pid != '0);
                    ticks_next    = sleep_ticks;
                    woken_next    = 1'b0;
                    tbl_raddr     = running_pid;
                    q_ctrl.start  = 1'b1;
                    unique case (func)
                        psu_pkg::FUNC_NEW:
                        begin
                            q_ctrl.finish = 1'b1;
                            if (free_count_reg == '0)
                            begin
                                q_ctrl.flags.err = psu_pkg::ERR_NO_PID;
                            end
                            else
                            begin
                                tbl_we            = 1'b1;
                                tbl_waddr         = free_head_reg;
                                tbl_wdata.st      = psu_pkg::ST_READY;
                                free_head_next    = free_head_reg + PW'(1);
                                free_count_next   = free_count_reg - CW'(1);
                                q_ctrl.flags.new_pid = free_head_reg;
                                // pid 0 is the idle process and is not reported
                                q_ctrl.push       = (free_head_reg != '0);
                                q_ctrl.push_pid   = free_head_reg;
                            end
                        end
                        psu_pkg::FUNC_TICK:
                        begin
                            clock_next = clock_reg + 32'd1;
                            state_next = S_PRE;
                        end
                        psu_pkg::FUNC_SLEEP:
                        begin
                            if (running_in)
                            begin
                                state_next = S_PRE;
                            end
                            else
                            begin
                                q_ctrl.finish = 1'b1;
                            end
                        end
                        psu_pkg::FUNC_WAIT:
                        begin
                            if (sem_number != psu_pkg::SEM_ID)
                            begin
                                q_ctrl.finish    = 1'b1;
                                q_ctrl.flags.err = psu_pkg::ERR_BAD_SEM;
                            end
                            else if (sem_value_reg != '0)
                            begin
                                q_ctrl.finish  = 1'b1;
                                sem_value_next = sem_value_reg - 16'd1;
                            end
                            else if (running_in &&
                                     (wcount_reg < CW'(psu_pkg::MAX_RESULTS)))
                            begin
                                fifo_we     = 1'b1;
                                wcount_next = wcount_reg + CW'(1);
                                state_next  = S_PRE;
                            end
                            else
                            begin
                                q_ctrl.finish = 1'b1;
                            end
                        end
                        psu_pkg::FUNC_POST:
                        begin
                            if (sem_number != psu_pkg::SEM_ID)
                            begin
                                q_ctrl.finish    = 1'b1;
                                q_ctrl.flags.err = psu_pkg::ERR_BAD_SEM;
                            end
                            else if (wcount_reg == '0)
                            begin
                                q_ctrl.finish = 1'b1;
                                if (sem_value_reg != 16'hFFFF)
                                begin
                                    sem_value_next = sem_value_reg + 16'd1;
                                end
                            end
                            else
                            begin
                                whead_next  = whead_reg + PW'(1);
                                wcount_next = wcount_reg - CW'(1);
                                state_next  = S_FIFO;
                            end
                        end
                        default:
                        begin
                            q_ctrl.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_PRE:
            begin
                // Entry of the running process is available.
                unique case (op_reg)
                    psu_pkg::FUNC_TICK:
                    begin
                        rel_next     = charged_reg && (run_inc >= slice_reg);
                        run_new_next = (charged_reg && (run_inc >= slice_reg)) ? 16'd0 : run_inc;
                        tbl_raddr    = '0;
                        walk_next    = '0;
                        state_next   = S_WALK;
                    end
                    psu_pkg::FUNC_SLEEP:
                    begin
                        tbl_we            = 1'b1;
                        tbl_waddr         = rpid_reg;
                        tbl_wdata         = entry_rd;
                        tbl_wdata.st      = psu_pkg::ST_SLEEP;
                        tbl_wdata.wake    = clock_reg + ticks_reg;
                        q_ctrl.finish     = 1'b1;
                        q_ctrl.flags.rel  = 1'b1;
                        state_next        = S_IDLE;
                    end
                    default:
                    begin
                        tbl_we            = 1'b1;
                        tbl_waddr         = rpid_reg;
                        tbl_wdata         = entry_rd;
                        tbl_wdata.st      = psu_pkg::ST_WAIT;
                        q_ctrl.finish     = 1'b1;
                        q_ctrl.flags.rel  = 1'b1;
                        state_next        = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                tbl_we          = 1'b1;
                tbl_waddr       = walk_reg;
                tbl_wdata       = walk_entry;
                q_ctrl.push     = wake_hit;
                q_ctrl.push_pid = walk_reg;
                if (wake_hit && running_reg && (walk_reg == rpid_reg))
                begin
                    woken_next = 1'b1;
                end
                tbl_raddr = walk_reg + PW'(1);
                walk_next = walk_reg + PW'(1);
                if (walk_reg == PW'(psu_pkg::PID_SLOTS - 1))
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                q_ctrl.push      = rel_reg && !woken_reg;
                q_ctrl.push_pid  = rpid_reg;
                q_ctrl.finish    = 1'b1;
                q_ctrl.flags.rel = rel_reg;
                state_next       = S_IDLE;
            end
            S_FIFO:
            begin
                tbl_raddr     = fifo_rdata;
                post_pid_next = fifo_rdata;
                state_next    = S_POST;
            end
            S_POST:
            begin
                tbl_we          = 1'b1;
                tbl_waddr       = post_pid_reg;
                tbl_wdata       = entry_rd;
                tbl_wdata.st    = psu_pkg::ST_READY;
                q_ctrl.push     = 1'b1;
                q_ctrl.push_pid = post_pid_reg;
                q_ctrl.finish   = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (tbl_we)
        begin
            valid_next[tbl_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slice_reg      <= psu_pkg::SLICE_RESET;
            clock_reg      <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CW'(psu_pkg::PID_SLOTS);
            sem_value_reg  <= 16'd1;
            whead_reg      <= '0;
            wcount_reg     <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            walk_reg       <= '0;
            rel_reg        <= 1'b0;
            woken_reg      <= 1'b0;
            running_reg    <= 1'b0;
            charged_reg    <= 1'b0;
            op_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_write)
            begin
                slice_reg <= pwdata[15:0];
            end
            clock_reg      <= clock_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            sem_value_reg  <= sem_value_next;
            whead_reg      <= whead_next;
            wcount_reg     <= wcount_next;
            valid_reg      <= valid_next;
            rd_valid_reg   <= valid_reg[tbl_raddr];
            walk_reg       <= walk_next;
            rel_reg        <= rel_next;
            woken_reg      <= woken_next;
            running_reg    <= running_next;
            charged_reg    <= charged_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpid_reg     <= rpid_next;
        ticks_reg    <= ticks_next;
        run_new_reg  <= run_new_next;
        post_pid_reg <= post_pid_next;
    end

    psu_ram #(
        .WIDTH (psu_pkg::ENTRY_W),
        .DEPTH (psu_pkg::TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // The waiter is written in the cycle of acceptance, straight from the input.
    psu_ram #(
        .WIDTH (psu_pkg::PID_W),
        .DEPTH (psu_pkg::MAX_RESULTS)
    ) u_waiters (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (running_pid),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    psu_result_queue u_results (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (q_ctrl),
        .busy            (q_busy),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .ready_pid       (ready_pid),
        .ready_valid     (ready_valid),
        .release_running (release_running),
        .new_pid         (new_pid),
        .error_code      (error_code),
        .last            (last)
    );

`ifndef SYNTH
    // Inputs are never taken while results of the previous transaction remain.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while results are pending");

    // The final result of a transaction ends the output stream.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("output stream continued after last result");

    // The free pid count never exceeds the number of slots.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CW'(psu_pkg::PID_SLOTS))
        else $error("free pid count out of range");
`endif

endmodule

`default_nettype wire

/* sv/psu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/psu_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Collects the readied pids of one operation and then streams them out.
module psu_result_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire psu_pkg::q_ctrl_t               ctrl,
    output logic                                busy,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic      [psu_pkg::PID_W-1:0]      ready_pid,
    output logic                                ready_valid,
    output logic                                release_running,
    output logic      [psu_pkg::PID_W-1:0]      new_pid,
    output logic      [1:0]                     error_code,
    output logic                                last
);

    logic [psu_pkg::PID_W-1:0] list_reg [psu_pkg::MAX_RESULTS];
    logic [psu_pkg::CNT_W-1:0] count_reg, count_next;
    logic [psu_pkg::PID_W-1:0] idx_reg, idx_next;
    logic                      stream_reg, stream_next;
    psu_pkg::flags_t           flags_reg;
    logic                      wr_en;
    logic [psu_pkg::PID_W-1:0] wr_idx;
    logic                      room;

    assign room   = count_reg < psu_pkg::CNT_W'(psu_pkg::MAX_RESULTS);
    assign wr_en  = ctrl.push && (ctrl.start || room);
    assign wr_idx = ctrl.start ? '0 : count_reg[psu_pkg::PID_W-1:0];

    assign last = (count_reg == '0) ||
                  ({1'b0, idx_reg} == (count_reg - psu_pkg::CNT_W'(1)));

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        stream_next = stream_reg;
        if (ctrl.start)
        begin
            count_next = ctrl.push ? psu_pkg::CNT_W'(1) : '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + psu_pkg::CNT_W'(1);
        end
        if (ctrl.finish)
        begin
            stream_next = 1'b1;
            idx_next    = '0;
        end
        else if (stream_reg && out_ready)
        begin
            if (last)
            begin
                stream_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + psu_pkg::PID_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            stream_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            stream_reg <= stream_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_reg[wr_idx] <= ctrl.push_pid;
        end
        if (ctrl.finish)
        begin
            flags_reg <= ctrl.flags;
        end
    end

    assign busy            = stream_reg;
    assign out_valid       = stream_reg;
    assign ready_valid     = (count_reg != '0);
    assign ready_pid       = ready_valid ? list_reg[idx_reg] : '0;
    assign release_running = flags_reg.rel;
    assign new_pid         = flags_reg.new_pid;
    assign error_code      = flags_reg.err;

endmodule

`default_nettype wire

/* tb/tb_process_tick_sleep_semaphore_unit.sv */
`timescale 1ns / 1ps

module tb_process_tick_sleep_semaphore_unit;

    // Clock, reset and the ports of the block.
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [3:0]  running_pid;
    logic        running_valid;
    logic [31:0] sleep_ticks;
    logic [3:0]  sem_number;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  ready_pid;
    logic        ready_valid;
    logic        release_running;
    logic [3:0]  new_pid;
    logic [1:0]  error_code;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    process_tick_sleep_semaphore_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .running_pid(running_pid), .running_valid(running_valid),
        .sleep_ticks(sleep_ticks), .sem_number(sem_number),
        .out_valid(out_valid), .out_ready(out_ready), .ready_pid(ready_pid),
        .ready_valid(ready_valid), .release_running(release_running),
        .new_pid(new_pid), .error_code(error_code), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // One operation as presented on the input channel.
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  pid;
        logic        pid_ok;
        logic [31:0] ticks;
        logic [3:0]  sem;
    } op_item_t;

    // One result as it should appear on the output channel.
    typedef struct packed {
        logic [3:0] rpid;
        logic       rvalid;
        logic       rel;
        logic [3:0] npid;
        logic [1:0] err;
        logic       lst;
    } ready_rec_t;

    op_item_t   op_queue[$];
    ready_rec_t ready_expect[$];

    // Private copy of the block's state.
    logic [15:0] m_slice;
    logic [1:0]  m_state[16];
    logic [31:0] m_wake[16];
    logic [15:0] m_run[16];
    logic [31:0] m_clock;
    logic [3:0]  m_free_fifo[16];
    logic [3:0]  m_free_head;
    int          m_free_count;
    int          m_sem;
    logic [3:0]  m_wait_fifo[16];
    logic [3:0]  m_wait_head;
    int          m_wait_count;

    int errors;
    int mismatches;
    int results_seen;
    int items_sent;
    int wakeups_seen;
    bit driving_done;
    bit in_taken;

    task automatic model_reset();
        m_slice = psu_pkg::SLICE_RESET;
        for (int i = 0; i < 16; i++)
        begin
            m_state[i] = psu_pkg::ST_FREE;
            m_wake[i] = '0;
            m_run[i] = '0;
            m_free_fifo[i] = i[3:0];
            m_wait_fifo[i] = '0;
        end
        m_clock = '0;
        m_free_head = '0;
        m_free_count = psu_pkg::PID_SLOTS;
        m_sem = 1;
        m_wait_head = '0;
        m_wait_count = 0;
    endtask

    // Works out the results of one operation and queues them in order.
    task automatic predict_readied(input op_item_t it);
        logic [3:0] pids[$];
        logic       rel;
        logic [3:0] np;
        logic [1:0] er;
        bit         running;
        bit         run_woken;
        logic [3:0] p;
        ready_rec_t r;
        rel = 1'b0;
        np = '0;
        er = psu_pkg::ERR_NONE;
        run_woken = 0;
        running = it.pid_ok && (int'(it.pid) < psu_pkg::PID_SLOTS);
        case (it.op)
            psu_pkg::FUNC_NEW:
            begin
                if (m_free_count == 0)
                    er = psu_pkg::ERR_NO_PID;
                else
                begin
                    p = m_free_fifo[m_free_head];
                    m_free_head = m_free_head + 1'b1;
                    m_free_count--;
                    m_wake[p] = '0;
                    m_run[p] = '0;
                    m_state[p] = psu_pkg::ST_READY;
                    np = p;
                    if (p != 0)
                        pids.push_back(p);
                end
            end
            psu_pkg::FUNC_TICK:
            begin
                m_clock = m_clock + 1;
                for (int i = 0; i < psu_pkg::PID_SLOTS; i++)
                begin
                    if (m_state[i] == psu_pkg::ST_SLEEP && m_wake[i] == m_clock)
                    begin
                        m_state[i] = psu_pkg::ST_READY;
                        pids.push_back(i[3:0]);
                        if (running && i == it.pid)
                            run_woken = 1;
                    end
                end
                if (running && it.pid != 0)
                begin
                    if (m_run[it.pid] != 16'hFFFF)
                        m_run[it.pid] = m_run[it.pid] + 1'b1;
                    if (m_run[it.pid] >= m_slice)
                    begin
                        m_state[it.pid] = psu_pkg::ST_READY;
                        m_run[it.pid] = '0;
                        rel = 1'b1;
                        if (!run_woken)
                            pids.push_back(it.pid);
                    end
                end
            end
            psu_pkg::FUNC_SLEEP:
            begin
                if (running)
                begin
                    m_wake[it.pid] = m_clock + it.ticks;
                    m_state[it.pid] = psu_pkg::ST_SLEEP;
                    rel = 1'b1;
                end
            end
            psu_pkg::FUNC_WAIT:
            begin
                if (it.sem != psu_pkg::SEM_ID)
                    er = psu_pkg::ERR_BAD_SEM;
                else if (m_sem > 0)
                    m_sem--;
                else if (running && m_wait_count < 16)
                begin
                    m_wait_fifo[m_wait_head + m_wait_count[3:0]] = it.pid;
                    m_wait_count++;
                    m_state[it.pid] = psu_pkg::ST_WAIT;
                    rel = 1'b1;
                end
            end
            psu_pkg::FUNC_POST:
            begin
                if (it.sem != psu_pkg::SEM_ID)
                    er = psu_pkg::ERR_BAD_SEM;
                else if (m_wait_count == 0)
                begin
                    if (m_sem < 65535)
                        m_sem++;
                end
                else
                begin
                    p = m_wait_fifo[m_wait_head];
                    m_wait_head = m_wait_head + 1'b1;
                    m_wait_count--;
                    m_state[p] = psu_pkg::ST_READY;
                    pids.push_back(p);
                end
            end
            default:
            begin
            end
        endcase
        while (pids.size() > psu_pkg::MAX_RESULTS)
            void'(pids.pop_back());
        wakeups_seen += pids.size();
        if (pids.size() == 0)
        begin
            r = '{rpid: 4'd0, rvalid: 1'b0, rel: rel, npid: np, err: er, lst: 1'b1};
            ready_expect.push_back(r);
        end
        for (int k = 0; k < pids.size(); k++)
        begin
            r = '{rpid: pids[k], rvalid: 1'b1, rel: rel, npid: np, err: er,
                  lst: (k == pids.size() - 1)};
            ready_expect.push_back(r);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Acceptance is seen at the rising edge, where the handshake counts.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_readied({func, running_pid, running_valid, sleep_ticks,
                             sem_number});
            items_sent++;
            in_taken = 1'b1;
        end
    end

    // Driver: bursts of transactions separated by random gaps. Inputs move
    // only on the falling edge, and valid stays high between back-to-back
    // transactions so that it is assigned once per step.
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                in_taken = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    op_item_t it;
                    it = op_queue.pop_front();
                    func <= it.op;
                    running_pid <= it.pid;
                    running_valid <= it.pid_ok;
                    sleep_ticks <= it.ticks;
                    sem_number <= it.sem;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                    driving_done = 1;
                end
            end
        end
    end

    // The receiver runs on a pattern of its own: a slowly changing mode picks
    // no stalls, light stalls or heavy stalls.
    int stall_mode;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Monitor: compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            ready_rec_t got;
            ready_rec_t want;
            got = '{rpid: ready_pid, rvalid: ready_valid, rel: release_running,
                    npid: new_pid, err: error_code, lst: last};
            results_seen++;
            if (ready_expect.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
            end
            else
            begin
                want = ready_expect.pop_front();
                if (got !== want)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result mismatch, expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic op_item_t make_op(input logic [2:0] op, input logic [3:0] pid,
                                         input logic ok, input logic [31:0] t,
                                         input logic [3:0] s);
        make_op = '{op: op, pid: pid, pid_ok: ok, ticks: t, sem: s};
    endfunction

    // A random operation; most are well formed against the known semaphore,
    // with short sleeps so that ticks actually wake processes.
    function automatic op_item_t random_op();
        op_item_t it;
        int sel;
        sel = $urandom_range(0, 99);
        it.pid = 4'($urandom);
        it.pid_ok = ($urandom_range(0, 9) != 0);
        it.sem = ($urandom_range(0, 9) == 0) ? 4'($urandom) : psu_pkg::SEM_ID;
        it.ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
        if (sel < 10)      it.op = psu_pkg::FUNC_NEW;
        else if (sel < 55) it.op = psu_pkg::FUNC_TICK;
        else if (sel < 70) it.op = psu_pkg::FUNC_SLEEP;
        else if (sel < 82) it.op = psu_pkg::FUNC_WAIT;
        else if (sel < 96) it.op = psu_pkg::FUNC_POST;
        else               it.op = 3'($urandom_range(5, 7));
        return it;
    endfunction

    // APB write in a setup cycle and an access cycle; the block is idle here.
    task automatic write_slice(input logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        m_slice = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits for the queue to drain, the driver to go idle and all results to
    // arrive, then a little longer for the block to settle.
    task automatic wait_idle();
        while (op_queue.size() > 0 || !driving_done || in_valid || ready_expect.size() > 0)
            @(posedge clk);
        repeat (psu_pkg::PID_SLOTS + 10) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] slices[5];
        errors = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        wakeups_seen = 0;
        driving_done = 0;
        in_taken = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        running_pid = '0;
        running_valid = 1'b0;
        sleep_ticks = '0;
        sem_number = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        model_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed phase at the reset slice limit: allocation, sleeps with the
        // zero and the maximum count, ticks that wake and charge, semaphore
        // waits and posts, a bad semaphore, an unknown operation and a dispatcher
        // reporting a missing running process.
        op_queue.push_back(make_op(psu_pkg::FUNC_NEW, 4'd0, 1'b0, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_NEW, 4'd0, 1'b0, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_NEW, 4'd0, 1'b0, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_SLEEP, 4'd1, 1'b1, 32'd2, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_SLEEP, 4'd2, 1'b1, 32'hFFFFFFFF, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_SLEEP, 4'd0, 1'b1, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_TICK, 4'd15, 1'b1, 32'd0, 4'd15));
        op_queue.push_back(make_op(psu_pkg::FUNC_TICK, 4'd1, 1'b1, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_SLEEP, 4'd3, 1'b0, 32'd1, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_WAIT, 4'd1, 1'b1, 32'd0, psu_pkg::SEM_ID));
        op_queue.push_back(make_op(psu_pkg::FUNC_WAIT, 4'd1, 1'b1, 32'd0, psu_pkg::SEM_ID));
        op_queue.push_back(make_op(psu_pkg::FUNC_WAIT, 4'd2, 1'b0, 32'd0, psu_pkg::SEM_ID));
        op_queue.push_back(make_op(psu_pkg::FUNC_WAIT, 4'd2, 1'b1, 32'd0, 4'd15));
        op_queue.push_back(make_op(psu_pkg::FUNC_POST, 4'd0, 1'b0, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_POST, 4'd0, 1'b0, 32'd0, psu_pkg::SEM_ID));
        op_queue.push_back(make_op(psu_pkg::FUNC_POST, 4'd0, 1'b0, 32'd0, psu_pkg::SEM_ID));
        op_queue.push_back(make_op(3'd5, 4'd0, 1'b0, 32'd0, 4'd0));
        op_queue.push_back(make_op(3'd7, 4'd15, 1'b1, 32'hFFFFFFFF, 4'd15));
        for (int i = 0; i < 16; i++)
            op_queue.push_back(make_op(psu_pkg::FUNC_NEW, 4'd0, 1'b0, 32'd0, 4'd0));
        wait_idle();

        // Slice limit of one preempts on every charged tick; the highest pid, 15,
        // is charged here too.
        write_slice(16'd1);
        for (int i = 0; i < 4; i++)
            op_queue.push_back(make_op(psu_pkg::FUNC_TICK, i[3:0] + 4'd1, 1'b1, 32'd0, 4'd0));
        op_queue.push_back(make_op(psu_pkg::FUNC_TICK, 4'd15, 1'b1, 32'd0, 4'd0));
        driving_done = 0;
        wait_idle();

        // Random phases over several slice limits, the extremes among them.
        // A zero limit is written too, since the register takes it.
        slices = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd300};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_slice(slices[ph]);
            for (int i = 0; i < 52; i++)
                op_queue.push_back(random_op());
            driving_done = 0;
            wait_idle();
        end

        $display("Run covered %0d operations, %0d results, %0d readied pids,",
                 items_sent, results_seen, wakeups_seen);
        $display("over seven phases with slice limits from zero to the maximum.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout: the run did not finish in time.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
sv/psu_pkg.sv
sv/psu_ram.sv
sv/psu_result_queue.sv
sv/process_tick_sleep_semaphore_unit.sv
tb/tb_process_tick_sleep_semaphore_unit.sv
